FILE: hdl/hit_cluster_summarizer_assert.svh
// assertion macros for the hit cluster summarizer
`ifndef HIT_CLUSTER_SUMMARIZER_ASSERT_SVH
`define HIT_CLUSTER_SUMMARIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define HCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define HCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define HCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/hcs_pkg.sv
package hcs_pkg;

    // cluster size limit and derived widths
    localparam int MAX_HITS = 64;
    localparam int LOG_W    = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CNT_W    = $clog2(MAX_HITS + 1);
    localparam int SUM_W    = 16 + LOG_W;
    localparam int POS_W    = SUM_W + 1;
    localparam int PAIR_W   = 10 + LOG_W;
    localparam int DIVD_W   = SUM_W + 8;
    localparam int QUOT_W   = 24;
    localparam int STEP_W   = $clog2(DIVD_W);

    // stream widths
    localparam int S_DATA_W = 176;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 4;

    // input item field offsets in s_tdata
    localparam int OFS_PE    = 0;
    localparam int OFS_HI    = 16;
    localparam int OFS_LO    = 32;
    localparam int OFS_X     = 48;
    localparam int OFS_Y     = 64;
    localparam int OFS_AZ    = 80;
    localparam int OFS_R     = 96;
    localparam int OFS_Z     = 112;
    localparam int OFS_PAIR  = 128;
    localparam int OFS_TIME  = 138;
    localparam int OFS_WIDTH = 154;

    // result quantity codes
    typedef enum logic [3:0] {
        QTY_PE_TOTAL  = 4'd0,
        QTY_PE_MAX    = 4'd1,
        QTY_HI_TOTAL  = 4'd2,
        QTY_HI_MAX    = 4'd3,
        QTY_LO_TOTAL  = 4'd4,
        QTY_LO_MAX    = 4'd5,
        QTY_MEAN_PAIR = 4'd6,
        QTY_MEAN_X    = 4'd7,
        QTY_MEAN_Y    = 4'd8,
        QTY_MEAN_PHI  = 4'd9,
        QTY_MEAN_R    = 4'd10,
        QTY_MEAN_Z0   = 4'd11,
        QTY_TIME      = 4'd12,
        QTY_WIDTH     = 4'd13,
        QTY_COUNT     = 4'd14
    } qty_t;

    // controller states
    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_NEXT,
        ST_DIV,
        ST_PUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept_hit;
        logic clear;
        logic div_start;
        logic load_out;
        qty_t qty;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_free;
    } status_t;

    // magnitude of a 16 bit signed value
    function automatic logic [16:0] abs16(logic [15:0] v);
        logic signed [16:0] e;
        e = $signed({v[15], v});
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

endpackage

FILE: hdl/hit_cluster_summarizer.sv
// hits: one item per cycle while collecting; the sums hold each of the first MAX_HITS hits from the next cycle
// summary: 15 result items after the last hit; each plain result passes ST_NEXT and ST_PUT,
// each of the 6 means also waits in ST_DIV for the bit-serial divider (30 steps)
// after the last hit, each result is loaded into the output register from ST_PUT once that register is free
// next cluster is taken once the final result is in the output register
// rst_n (async, active low) clears all sums, maxima, counters and the output valid
`include "hit_cluster_summarizer_assert.svh"

module hit_cluster_summarizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // photon_num, energy_hi, energy_lo, pos_x, pos_y, azimuth, radius,
    // z_origin, pair_number, corr_time, pulse_width, zero fill
    input  logic [hcs_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // value
    output logic [hcs_pkg::M_DATA_W-1:0] m_tdata,
    // quantity
    output logic [hcs_pkg::M_USER_W-1:0] m_tuser,
    output logic                         m_tlast
);
    import hcs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    hcs_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // accumulators, divider and output register
    hcs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // checks
    `HCS_ASSERT_IMPLY(a_last_on_count, clk, rst_n, m_tvalid,
        m_tlast == (m_tuser == QTY_COUNT), "last flag not on count item")
    `HCS_ASSERT_IMPLY(a_no_hit_while_div, clk, rst_n, status.div_busy,
        !s_tready, "hit taken while dividing")
    `HCS_ASSERT_NEXT(a_collect_after_count, clk, rst_n,
        cmd.load_out && cmd.qty == QTY_COUNT, s_tready, "no return to collect")
    `HCS_ASSERT_IMPLY(a_count_range, clk, rst_n, m_tvalid && m_tuser == QTY_COUNT,
        m_tdata <= M_DATA_W'(MAX_HITS), "hit count over limit")

endmodule

FILE: hdl/hcs_divider.sv
module hcs_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hcs_pkg::DIVD_W-1:0] dividend,
    input  logic [hcs_pkg::CNT_W-1:0]  divisor,
    output logic                      busy,
    output logic                      done,
    output logic [hcs_pkg::DIVD_W-1:0] quotient
);
    import hcs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // one restoring step per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = trial - {1'b0, div_reg};
        fits      = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/hcs_datapath.sv
module hcs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcs_pkg::cmd_t                 cmd,
    output hcs_pkg::status_t              status,
    input  logic [hcs_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hcs_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [hcs_pkg::M_USER_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import hcs_pkg::*;

    // hit fields
    logic [15:0] f_pe, f_hi, f_lo, f_x, f_y, f_az, f_r, f_z, f_time, f_width;
    logic [9:0]  f_pair;

    // accumulators
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SUM_W-1:0]        sum_pe_reg, sum_pe_next;
    logic [SUM_W-1:0]        sum_hi_reg, sum_hi_next;
    logic [SUM_W-1:0]        sum_lo_reg, sum_lo_next;
    logic [15:0]             max_pe_reg, max_pe_next;
    logic [15:0]             max_hi_reg, max_hi_next;
    logic [15:0]             max_lo_reg, max_lo_next;
    logic signed [POS_W-1:0] sum_x_reg, sum_x_next;
    logic signed [POS_W-1:0] sum_y_reg, sum_y_next;
    logic signed [POS_W-1:0] sum_z_reg, sum_z_next;
    logic [SUM_W-1:0]        sum_az_reg, sum_az_next;
    logic [SUM_W-1:0]        sum_r_reg, sum_r_next;
    logic [PAIR_W-1:0]       sum_pair_reg, sum_pair_next;
    logic [15:0]             time_reg, time_next;
    logic signed [15:0]      width_reg, width_next;
    logic                    absent_reg, absent_next;
    logic                    take;

    // divider operands and result
    logic signed [POS_W-1:0] div_src;
    logic [POS_W-1:0]        div_mag;
    logic [DIVD_W-1:0]       dividend;
    logic                    neg_reg, neg_next;
    logic                    div_busy, div_done;
    logic [DIVD_W-1:0]       quotient;
    logic [M_DATA_W-1:0]     mean_val;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_value_reg, out_value_next;
    logic [M_USER_W-1:0] out_qty_reg, out_qty_next;
    logic                out_last_reg, out_last_next;
    logic [M_DATA_W-1:0] sel_value;
    logic                out_free;

    // field unpacking
    assign f_pe    = s_tdata[OFS_PE+15:OFS_PE];
    assign f_hi    = s_tdata[OFS_HI+15:OFS_HI];
    assign f_lo    = s_tdata[OFS_LO+15:OFS_LO];
    assign f_x     = s_tdata[OFS_X+15:OFS_X];
    assign f_y     = s_tdata[OFS_Y+15:OFS_Y];
    assign f_az    = s_tdata[OFS_AZ+15:OFS_AZ];
    assign f_r     = s_tdata[OFS_R+15:OFS_R];
    assign f_z     = s_tdata[OFS_Z+15:OFS_Z];
    assign f_pair  = s_tdata[OFS_PAIR+9:OFS_PAIR];
    assign f_time  = s_tdata[OFS_TIME+15:OFS_TIME];
    assign f_width = s_tdata[OFS_WIDTH+15:OFS_WIDTH];

    assign take = cmd.accept_hit && (cnt_reg < CNT_W'(MAX_HITS));

    // hit accumulation
    always_comb
    begin
        cnt_next      = cnt_reg;
        sum_pe_next   = sum_pe_reg;
        sum_hi_next   = sum_hi_reg;
        sum_lo_next   = sum_lo_reg;
        max_pe_next   = max_pe_reg;
        max_hi_next   = max_hi_reg;
        max_lo_next   = max_lo_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        sum_z_next    = sum_z_reg;
        sum_az_next   = sum_az_reg;
        sum_r_next    = sum_r_reg;
        sum_pair_next = sum_pair_reg;
        time_next     = time_reg;
        width_next    = width_reg;
        absent_next   = absent_reg;
        if (cmd.clear)
        begin
            cnt_next      = '0;
            sum_pe_next   = '0;
            sum_hi_next   = '0;
            sum_lo_next   = '0;
            max_pe_next   = '0;
            max_hi_next   = '0;
            max_lo_next   = '0;
            sum_x_next    = '0;
            sum_y_next    = '0;
            sum_z_next    = '0;
            sum_az_next   = '0;
            sum_r_next    = '0;
            sum_pair_next = '0;
            time_next     = '0;
            width_next    = '0;
            absent_next   = 1'b0;
        end
        else if (take)
        begin
            cnt_next      = cnt_reg + 1'b1;
            sum_pe_next   = sum_pe_reg + SUM_W'(f_pe);
            sum_hi_next   = sum_hi_reg + SUM_W'(f_hi);
            sum_lo_next   = sum_lo_reg + SUM_W'(f_lo);
            max_pe_next   = (f_pe > max_pe_reg) ? f_pe : max_pe_reg;
            max_hi_next   = (f_hi > max_hi_reg) ? f_hi : max_hi_reg;
            max_lo_next   = (f_lo > max_lo_reg) ? f_lo : max_lo_reg;
            sum_x_next    = sum_x_reg + POS_W'($signed(f_x));
            sum_y_next    = sum_y_reg + POS_W'($signed(f_y));
            sum_z_next    = sum_z_reg + POS_W'($signed(f_z));
            sum_az_next   = sum_az_reg + SUM_W'(f_az);
            sum_r_next    = sum_r_reg + SUM_W'(f_r);
            sum_pair_next = sum_pair_reg + PAIR_W'(f_pair);
            // first hit seeds time and width
            if (cnt_reg == '0)
            begin
                time_next   = f_time;
                width_next  = $signed(f_width);
                absent_next = ($signed(f_width) == -16'sd1);
            end
            else
            begin
                if (abs16(f_time) < abs16(time_reg))
                begin
                    time_next = f_time;
                end
                if ($signed(f_width) > width_reg)
                begin
                    width_next = $signed(f_width);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            sum_pe_reg   <= '0;
            sum_hi_reg   <= '0;
            sum_lo_reg   <= '0;
            max_pe_reg   <= '0;
            max_hi_reg   <= '0;
            max_lo_reg   <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_z_reg    <= '0;
            sum_az_reg   <= '0;
            sum_r_reg    <= '0;
            sum_pair_reg <= '0;
            time_reg     <= '0;
            width_reg    <= '0;
            absent_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            sum_pe_reg   <= sum_pe_next;
            sum_hi_reg   <= sum_hi_next;
            sum_lo_reg   <= sum_lo_next;
            max_pe_reg   <= max_pe_next;
            max_hi_reg   <= max_hi_next;
            max_lo_reg   <= max_lo_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            sum_z_reg    <= sum_z_next;
            sum_az_reg   <= sum_az_next;
            sum_r_reg    <= sum_r_next;
            sum_pair_reg <= sum_pair_next;
            time_reg     <= time_next;
            width_reg    <= width_next;
            absent_reg   <= absent_next;
        end
    end

    // pick the sum for the mean being computed
    always_comb
    begin
        case (cmd.qty)
            QTY_MEAN_PAIR: div_src = $signed(POS_W'(sum_pair_reg));
            QTY_MEAN_X:    div_src = sum_x_reg;
            QTY_MEAN_Y:    div_src = sum_y_reg;
            QTY_MEAN_PHI:  div_src = $signed(POS_W'(sum_az_reg));
            QTY_MEAN_R:    div_src = $signed(POS_W'(sum_r_reg));
            QTY_MEAN_Z0:   div_src = sum_z_reg;
            default:       div_src = '0;
        endcase
    end

    assign div_mag  = div_src[POS_W-1] ? POS_W'(-div_src) : POS_W'(div_src);
    assign dividend = {div_mag[SUM_W-1:0], 8'd0};
    assign neg_next = cmd.div_start ? div_src[POS_W-1] : neg_reg;

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

    hcs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // signed mean, zero when no hit was counted
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            mean_val = '0;
        end
        else if (neg_reg)
        begin
            mean_val = -M_DATA_W'(quotient[QUOT_W-1:0]);
        end
        else
        begin
            mean_val = M_DATA_W'(quotient[QUOT_W-1:0]);
        end
    end

    // result value select
    always_comb
    begin
        case (cmd.qty)
            QTY_PE_TOTAL:  sel_value = M_DATA_W'(sum_pe_reg);
            QTY_PE_MAX:    sel_value = M_DATA_W'(max_pe_reg);
            QTY_HI_TOTAL:  sel_value = M_DATA_W'(sum_hi_reg);
            QTY_HI_MAX:    sel_value = M_DATA_W'(max_hi_reg);
            QTY_LO_TOTAL:  sel_value = M_DATA_W'(sum_lo_reg);
            QTY_LO_MAX:    sel_value = M_DATA_W'(max_lo_reg);
            QTY_MEAN_PAIR,
            QTY_MEAN_X,
            QTY_MEAN_Y,
            QTY_MEAN_PHI,
            QTY_MEAN_R,
            QTY_MEAN_Z0:   sel_value = mean_val;
            QTY_TIME:      sel_value = M_DATA_W'($signed(time_reg));
            QTY_WIDTH:     sel_value = absent_reg ? '1 : M_DATA_W'(width_reg);
            QTY_COUNT:     sel_value = M_DATA_W'(cnt_reg);
            default:       sel_value = '0;
        endcase
    end

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_qty_next   = out_qty_reg;
        out_last_next  = out_last_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_value_next = sel_value;
            out_qty_next   = cmd.qty;
            out_last_next  = (cmd.qty == QTY_COUNT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_qty_reg   <= out_qty_next;
        out_last_reg  <= out_last_next;
    end

    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_qty_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hdl/hcs_controller.sv
module hcs_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  hcs_pkg::status_t status,
    output hcs_pkg::cmd_t    cmd
);
    import hcs_pkg::*;

    state_t state_reg, state_next;
    qty_t   qty_reg, qty_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        qty_next       = qty_reg;
        s_tready       = 1'b0;
        cmd.accept_hit = 1'b0;
        cmd.clear      = 1'b0;
        cmd.div_start  = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.qty        = qty_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                s_tready       = 1'b1;
                cmd.accept_hit = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_NEXT;
                    qty_next   = QTY_PE_TOTAL;
                end
            end
            ST_NEXT:
            begin
                // means go through the divider first
                if (qty_reg >= QTY_MEAN_PAIR && qty_reg <= QTY_MEAN_Z0)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (qty_reg == QTY_COUNT)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        qty_next   = qty_t'(qty_reg + 4'd1);
                        state_next = ST_NEXT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            qty_reg   <= QTY_PE_TOTAL;
        end
        else
        begin
            state_reg <= state_next;
            qty_reg   <= qty_next;
        end
    end

endmodule
